// ===== rtl/core/obbsat_pkg.sv =====
// ----------------------------------------------------------------------------
// obbsat_pkg: shared types and constants for the oriented box overlap unit
// Fixed widths of the box fields, the intermediate pipeline words and the
// configuration register map.
// ----------------------------------------------------------------------------
package obbsat_pkg;

    // Field widths.
    localparam int unsigned POS_W  = 31;   // Q16.16 signed center
    localparam int unsigned AXIS_W = 16;   // Q1.15 signed axis component
    localparam int unsigned EXT_W  = 30;   // Q16.16 unsigned half extent
    localparam int unsigned EPS_W  = 15;   // Q1.15 unsigned slack
    localparam int unsigned GAP_W  = 31;   // Q16.16 unsigned gap

    // Intermediate widths.
    localparam int unsigned OFS_W     = 32;  // center offset B - A
    localparam int unsigned APROD_W   = 32;  // axis times axis
    localparam int unsigned DOT_W     = 33;  // axis dot product, Q2.30
    localparam int unsigned ROT_W     = 18;  // rounded rotation entry, Q.15
    localparam int unsigned ABSR_W    = 17;  // |R| + epsilon
    localparam int unsigned TPROD_W   = 48;  // offset times axis
    localparam int unsigned TRAW_W    = 49;  // projected offset before rounding
    localparam int unsigned TA_W      = 34;  // projected offset, Q16.16
    localparam int unsigned ATA_W     = 33;  // |projected offset|
    localparam int unsigned RPROD_W   = 47;  // extent times |R|
    localparam int unsigned RAD_RAW_W = 48;  // radius before rounding
    localparam int unsigned RAD_W     = 34;  // radius, Q16.16
    localparam int unsigned PRAW_W    = 52;  // projection on B axis before rounding
    localparam int unsigned P_W       = 37;  // projection on B axis, Q16.16
    localparam int unsigned AP_W      = 36;  // |projection on B axis|
    localparam int unsigned DIST_W    = 40;  // signed axis separation

    localparam int unsigned RND_SHIFT = 15;
    localparam int unsigned RND_HALF  = 16384;

    // Stream and register port widths.
    localparam int unsigned S_TDATA_W  = 312;
    localparam int unsigned M_TDATA_W  = 32;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_IDX_W  = 1;

    // Register map, by word index.
    localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_EPSILON = 1'b0;
    localparam logic [EPS_W-1:0]     EPS_RESET            = 15'd1;

    typedef struct packed {
        logic signed [POS_W-1:0]  cx;
        logic signed [POS_W-1:0]  cy;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic        [EXT_W-1:0]  half_len;
        logic        [EXT_W-1:0]  half_wid;
    } box_t;

    typedef struct packed {
        box_t a;
        box_t b;
    } item_t;

    // Rotation between the frames and the raw offset projection onto A.
    typedef struct packed {
        logic signed [ROT_W-1:0]  r00;
        logic signed [ROT_W-1:0]  r01;
        logic signed [ROT_W-1:0]  r10;
        logic        [ABSR_W-1:0] ar00;
        logic        [ABSR_W-1:0] ar01;
        logic        [ABSR_W-1:0] ar10;
        logic        [ABSR_W-1:0] ar11;
        logic signed [TRAW_W-1:0] ta_raw0;
        logic signed [TRAW_W-1:0] ta_raw1;
        logic        [EXT_W-1:0]  a_half_len;
        logic        [EXT_W-1:0]  a_half_wid;
        logic        [EXT_W-1:0]  b_half_len;
        logic        [EXT_W-1:0]  b_half_wid;
    } frame_t;

    // Separations: best of the two A axes and each B axis.
    typedef struct packed {
        logic signed [DIST_W-1:0] d_a_max;
        logic signed [DIST_W-1:0] d_b0;
        logic signed [DIST_W-1:0] d_b1;
    } dist_t;

endpackage

// ===== rtl/core/oriented_box_overlap_and_gap_2d_unit.sv =====
// ----------------------------------------------------------------------------
// oriented_box_overlap_and_gap_2d_unit: 2D oriented box separating axis test
// Streams box pairs in, reports per pair whether they overlap and how far
// apart they are, with one configuration register for parallel slack.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the s_ channel carries one pair of boxes A and B, each
// with a Q16.16 center, a Q1.15 first axis and two Q16.16 half extents.
// Each pair gives exactly one transfer on the m_ channel: boxes_overlap and
// the saturated Q16.16 gap_estimate (zero when the boxes overlap).
// The pipeline has six register stages. A new pair is taken in every cycle
// while s_tready is high; the rate is set by the fully pipelined multiplier
// stages. Every stage has its own valid bit and moves up as soon as the stage
// ahead is empty or moving, so bubbles close up and s_tready drops only when
// all six stages hold data and the receiver keeps m_tready low. Nothing is
// lost or repeated while stalled.
// parallel_epsilon sits at byte address 0 on the register port and is read
// live by the pipeline, so the user must write it only while no pairs are in
// flight; the block itself does not enforce this. A synchronous reset
// (aresetn low) empties the pipeline and sets parallel_epsilon back to 1.
// ----------------------------------------------------------------------------
module oriented_box_overlap_and_gap_2d_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input pair channel.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata, low bit up: a_center_x[31], a_center_y[31], a_axis_x[16],
    // a_axis_y[16], a_half_len[30], a_half_wid[30], b_center_x[31],
    // b_center_y[31], b_axis_x[16], b_axis_y[16], b_half_len[30],
    // b_half_wid[30], zero pad[4].
    input  logic [obbsat_pkg::S_TDATA_W-1:0]      s_tdata,
    // Result channel.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata, low bit up: boxes_overlap[1], gap_estimate[31].
    output logic [obbsat_pkg::M_TDATA_W-1:0]      m_tdata,
    // Register port.
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [obbsat_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [obbsat_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [obbsat_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                  pready
);
    import obbsat_pkg::*;

    logic [EPS_W-1:0]     parallel_epsilon_reg, parallel_epsilon_next;
    logic [CFG_IDX_W-1:0] reg_index;
    logic                 cfg_write;

    item_t  in_item;
    frame_t frame;
    dist_t  axis_sep;
    logic   frame_valid, frame_ready;
    logic   dist_valid, dist_ready;
    logic   overlap;
    logic [GAP_W-1:0] gap;

    // Register port: zero wait states, register written on the access cycle.
    assign pready    = 1'b1;
    assign reg_index = paddr[CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        parallel_epsilon_next = parallel_epsilon_reg;
        prdata                = '0;
        unique case (reg_index)
            REG_PARALLEL_EPSILON: begin
                prdata = CFG_DATA_W'(parallel_epsilon_reg);
                if (cfg_write) begin
                    parallel_epsilon_next = pwdata[EPS_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parallel_epsilon_reg <= EPS_RESET;
        end else begin
            parallel_epsilon_reg <= parallel_epsilon_next;
        end
    end

    // Unpack the input transfer; the first field sits in the lowest bits.
    assign in_item.a.cx       = s_tdata[30:0];
    assign in_item.a.cy       = s_tdata[61:31];
    assign in_item.a.ax       = s_tdata[77:62];
    assign in_item.a.ay       = s_tdata[93:78];
    assign in_item.a.half_len = s_tdata[123:94];
    assign in_item.a.half_wid = s_tdata[153:124];
    assign in_item.b.cx       = s_tdata[184:154];
    assign in_item.b.cy       = s_tdata[215:185];
    assign in_item.b.ax       = s_tdata[231:216];
    assign in_item.b.ay       = s_tdata[247:232];
    assign in_item.b.half_len = s_tdata[277:248];
    assign in_item.b.half_wid = s_tdata[307:278];

    // Stages 1 and 2: rotation between the frames and the offset in A's frame.
    obbsat_frame u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .eps       (parallel_epsilon_reg),
        .out_valid (frame_valid),
        .out_ready (frame_ready),
        .out_frame (frame)
    );

    // Stages 3 to 5: projected radii and the four axis separations.
    obbsat_proj u_proj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (frame_valid),
        .in_ready  (frame_ready),
        .in_frame  (frame),
        .out_valid (dist_valid),
        .out_ready (dist_ready),
        .out_dist  (axis_sep)
    );

    // Stage 6: overlap decision, saturated gap and the output register.
    obbsat_gap u_gap (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (dist_valid),
        .in_ready      (dist_ready),
        .in_dist       (axis_sep),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .boxes_overlap (overlap),
        .gap_estimate  (gap)
    );

    assign m_tdata = {gap, overlap};

    // The overlap flag and the gap always agree: overlap exactly when zero gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[M_TDATA_W-1:1] == '0)))
        else $error("overlap flag disagrees with gap estimate");

    // Input back-pressure only arises from a full pipeline behind a stalled output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the output was free");

    // A register write to the slack register lands on the next edge.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_write && reg_index == REG_PARALLEL_EPSILON)
            |=> (parallel_epsilon_reg == $past(pwdata[EPS_W-1:0])))
        else $error("parallel_epsilon write lost");

endmodule

// ===== rtl/core/obbsat_frame.sv =====
// ----------------------------------------------------------------------------
// obbsat_frame: rotation and offset stages
// Two register stages: axis dot products and center offset, then the rounded
// rotation entries, their padded magnitudes and the offset projected onto A.
// ----------------------------------------------------------------------------
module obbsat_frame (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  obbsat_pkg::item_t                   in_item,
    input  logic [obbsat_pkg::EPS_W-1:0]        eps,
    output logic                                out_valid,
    input  logic                                out_ready,
    output obbsat_pkg::frame_t                  out_frame
);
    import obbsat_pkg::*;

    // Stage 1 registers.
    logic                      st1_valid_reg, st1_valid_next;
    logic signed [OFS_W-1:0]   t0_reg, t1_reg, t0_next, t1_next;
    logic signed [DOT_W-1:0]   d00_reg, d01_reg, d00_next, d01_next;
    logic signed [AXIS_W-1:0]  a_ax_reg, a_ay_reg;
    logic        [EXT_W-1:0]   a_hl_reg, a_hw_reg, b_hl_reg, b_hw_reg;
    // Stage 2 registers.
    logic                      st2_valid_reg, st2_valid_next;
    frame_t                    frame_reg, frame_next;

    logic st1_ready, st2_ready;

    logic signed [APROD_W-1:0] p_axbx, p_ayby, p_aybx, p_axby;
    logic signed [DOT_W:0]     s00, s01, s10;
    logic signed [ROT_W-1:0]   r00, r01, r10;
    logic        [ABSR_W-1:0]  m00, m01, m10;
    logic signed [TPROD_W-1:0] q_t0ax, q_t1ay, q_t1ax, q_t0ay;

    assign st2_ready = !st2_valid_reg || out_ready;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign in_ready  = st1_ready;
    assign out_valid = st2_valid_reg;
    assign out_frame = frame_reg;

    // Stage 1: center offset and the two independent axis dot products.
    always_comb begin
        t0_next  = OFS_W'(in_item.b.cx) - OFS_W'(in_item.a.cx);
        t1_next  = OFS_W'(in_item.b.cy) - OFS_W'(in_item.a.cy);
        p_axbx   = APROD_W'(in_item.a.ax * in_item.b.ax);
        p_ayby   = APROD_W'(in_item.a.ay * in_item.b.ay);
        p_aybx   = APROD_W'(in_item.a.ay * in_item.b.ax);
        p_axby   = APROD_W'(in_item.a.ax * in_item.b.ay);
        // A0.B0 and A0.B1 with B1 = (-by, bx); A1.B1 equals A0.B0 and
        // A1.B0 is the negation of A0.B1 before rounding.
        d00_next = DOT_W'(p_axbx) + DOT_W'(p_ayby);
        d01_next = DOT_W'(p_aybx) - DOT_W'(p_axby);
        st1_valid_next = st1_ready ? in_valid : st1_valid_reg;
    end

    // Stage 2: round to Q.15, pad magnitudes, project the offset onto A.
    always_comb begin
        s00 = (DOT_W+1)'(d00_reg) + (DOT_W+1)'(RND_HALF);
        s01 = (DOT_W+1)'(d01_reg) + (DOT_W+1)'(RND_HALF);
        s10 = -(DOT_W+1)'(d01_reg) + (DOT_W+1)'(RND_HALF);
        r00 = s00[ROT_W+RND_SHIFT-1:RND_SHIFT];
        r01 = s01[ROT_W+RND_SHIFT-1:RND_SHIFT];
        r10 = s10[ROT_W+RND_SHIFT-1:RND_SHIFT];
        m00 = ABSR_W'(r00 < 0 ? -r00 : r00) + ABSR_W'(eps);
        m01 = ABSR_W'(r01 < 0 ? -r01 : r01) + ABSR_W'(eps);
        m10 = ABSR_W'(r10 < 0 ? -r10 : r10) + ABSR_W'(eps);
        q_t0ax = TPROD_W'(t0_reg * a_ax_reg);
        q_t1ay = TPROD_W'(t1_reg * a_ay_reg);
        q_t1ax = TPROD_W'(t1_reg * a_ax_reg);
        q_t0ay = TPROD_W'(t0_reg * a_ay_reg);

        frame_next.r00        = r00;
        frame_next.r01        = r01;
        frame_next.r10        = r10;
        frame_next.ar00       = m00;
        frame_next.ar01       = m01;
        frame_next.ar10       = m10;
        frame_next.ar11       = m00;
        frame_next.ta_raw0    = TRAW_W'(q_t0ax) + TRAW_W'(q_t1ay);
        frame_next.ta_raw1    = TRAW_W'(q_t1ax) - TRAW_W'(q_t0ay);
        frame_next.a_half_len = a_hl_reg;
        frame_next.a_half_wid = a_hw_reg;
        frame_next.b_half_len = b_hl_reg;
        frame_next.b_half_wid = b_hw_reg;
        st2_valid_next = st2_ready ? st1_valid_reg : st2_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_ready) begin
            t0_reg   <= t0_next;
            t1_reg   <= t1_next;
            d00_reg  <= d00_next;
            d01_reg  <= d01_next;
            a_ax_reg <= in_item.a.ax;
            a_ay_reg <= in_item.a.ay;
            a_hl_reg <= in_item.a.half_len;
            a_hw_reg <= in_item.a.half_wid;
            b_hl_reg <= in_item.b.half_len;
            b_hw_reg <= in_item.b.half_wid;
        end
        if (st2_ready) begin
            frame_reg <= frame_next;
        end
    end

endmodule

// ===== rtl/core/obbsat_proj.sv =====
// ----------------------------------------------------------------------------
// obbsat_proj: radius and separation stages
// Three register stages: projected radii and rounded offset, separations on
// the A axes with projections onto B, then separations on the B axes.
// ----------------------------------------------------------------------------
module obbsat_proj (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  obbsat_pkg::frame_t   in_frame,
    output logic                 out_valid,
    input  logic                 out_ready,
    output obbsat_pkg::dist_t    out_dist
);
    import obbsat_pkg::*;

    // Stage 3 registers.
    logic                        st3_valid_reg, st3_valid_next;
    logic signed [TA_W-1:0]      ta0_reg, ta1_reg, ta0_next, ta1_next;
    logic        [RAD_RAW_W-1:0] rb0_raw_reg, rb1_raw_reg, ra0_raw_reg, ra1_raw_reg;
    logic        [RAD_RAW_W-1:0] rb0_raw_next, rb1_raw_next, ra0_raw_next, ra1_raw_next;
    logic signed [ROT_W-1:0]     r00_reg, r01_reg, r10_reg;
    logic        [EXT_W-1:0]     a_hl_reg, a_hw_reg, b_hl3_reg, b_hw3_reg;
    // Stage 4 registers.
    logic                        st4_valid_reg, st4_valid_next;
    logic signed [DIST_W-1:0]    da0_reg, da1_reg, da0_next, da1_next;
    logic signed [PRAW_W-1:0]    p0_raw_reg, p1_raw_reg, p0_raw_next, p1_raw_next;
    logic        [RAD_W-1:0]     ra0_reg, ra1_reg, ra0_next, ra1_next;
    logic        [EXT_W-1:0]     b_hl4_reg, b_hw4_reg;
    // Stage 5 register.
    logic                        st5_valid_reg, st5_valid_next;
    dist_t                       dist_reg, dist_next;

    logic st3_ready, st4_ready, st5_ready;

    logic signed [TA_W+RND_SHIFT:0] ts0, ts1;
    logic        [RPROD_W-1:0]      u0, u1, u2, u3, u4, u5, u6, u7;
    logic        [RAD_RAW_W:0]      rs_b0, rs_b1, rs_a0, rs_a1;
    logic        [RAD_W-1:0]        rb0, rb1;
    logic        [ATA_W-1:0]        ata0, ata1;
    logic signed [PRAW_W-1:0]       v00, v10, v01, v11;
    logic signed [PRAW_W:0]         ps0, ps1;
    logic signed [P_W-1:0]          pr0, pr1;
    logic        [AP_W-1:0]         ap0, ap1;

    assign st5_ready = !st5_valid_reg || out_ready;
    assign st4_ready = !st4_valid_reg || st5_ready;
    assign st3_ready = !st3_valid_reg || st4_ready;
    assign in_ready  = st3_ready;
    assign out_valid = st5_valid_reg;
    assign out_dist  = dist_reg;

    // Stage 3: round the projected offset, form the raw projected radii.
    always_comb begin
        ts0 = (TA_W+RND_SHIFT+1)'(in_frame.ta_raw0) + (TA_W+RND_SHIFT+1)'(RND_HALF);
        ts1 = (TA_W+RND_SHIFT+1)'(in_frame.ta_raw1) + (TA_W+RND_SHIFT+1)'(RND_HALF);
        ta0_next = ts0[TA_W+RND_SHIFT-1:RND_SHIFT];
        ta1_next = ts1[TA_W+RND_SHIFT-1:RND_SHIFT];
        u0 = RPROD_W'(in_frame.b_half_len) * RPROD_W'(in_frame.ar00);
        u1 = RPROD_W'(in_frame.b_half_wid) * RPROD_W'(in_frame.ar01);
        u2 = RPROD_W'(in_frame.b_half_len) * RPROD_W'(in_frame.ar10);
        u3 = RPROD_W'(in_frame.b_half_wid) * RPROD_W'(in_frame.ar11);
        u4 = RPROD_W'(in_frame.a_half_len) * RPROD_W'(in_frame.ar00);
        u5 = RPROD_W'(in_frame.a_half_wid) * RPROD_W'(in_frame.ar10);
        u6 = RPROD_W'(in_frame.a_half_len) * RPROD_W'(in_frame.ar01);
        u7 = RPROD_W'(in_frame.a_half_wid) * RPROD_W'(in_frame.ar11);
        rb0_raw_next = RAD_RAW_W'(u0) + RAD_RAW_W'(u1);
        rb1_raw_next = RAD_RAW_W'(u2) + RAD_RAW_W'(u3);
        ra0_raw_next = RAD_RAW_W'(u4) + RAD_RAW_W'(u5);
        ra1_raw_next = RAD_RAW_W'(u6) + RAD_RAW_W'(u7);
        st3_valid_next = st3_ready ? in_valid : st3_valid_reg;
    end

    // Stage 4: separations on the A axes, raw projections onto the B axes.
    always_comb begin
        rs_b0 = (RAD_RAW_W+1)'(rb0_raw_reg) + (RAD_RAW_W+1)'(RND_HALF);
        rs_b1 = (RAD_RAW_W+1)'(rb1_raw_reg) + (RAD_RAW_W+1)'(RND_HALF);
        rs_a0 = (RAD_RAW_W+1)'(ra0_raw_reg) + (RAD_RAW_W+1)'(RND_HALF);
        rs_a1 = (RAD_RAW_W+1)'(ra1_raw_reg) + (RAD_RAW_W+1)'(RND_HALF);
        rb0      = rs_b0[RAD_W+RND_SHIFT-1:RND_SHIFT];
        rb1      = rs_b1[RAD_W+RND_SHIFT-1:RND_SHIFT];
        ra0_next = rs_a0[RAD_W+RND_SHIFT-1:RND_SHIFT];
        ra1_next = rs_a1[RAD_W+RND_SHIFT-1:RND_SHIFT];
        ata0 = ATA_W'(ta0_reg < 0 ? -ta0_reg : ta0_reg);
        ata1 = ATA_W'(ta1_reg < 0 ? -ta1_reg : ta1_reg);
        da0_next = $signed(DIST_W'(ata0) - DIST_W'(a_hl_reg) - DIST_W'(rb0));
        da1_next = $signed(DIST_W'(ata1) - DIST_W'(a_hw_reg) - DIST_W'(rb1));
        // A1.B1 equals A0.B0, so r00 serves both.
        v00 = PRAW_W'(ta0_reg * r00_reg);
        v10 = PRAW_W'(ta1_reg * r10_reg);
        v01 = PRAW_W'(ta0_reg * r01_reg);
        v11 = PRAW_W'(ta1_reg * r00_reg);
        p0_raw_next = v00 + v10;
        p1_raw_next = v01 + v11;
        st4_valid_next = st4_ready ? st3_valid_reg : st4_valid_reg;
    end

    // Stage 5: separations on the B axes and the larger A axis separation.
    always_comb begin
        ps0 = (PRAW_W+1)'(p0_raw_reg) + (PRAW_W+1)'(RND_HALF);
        ps1 = (PRAW_W+1)'(p1_raw_reg) + (PRAW_W+1)'(RND_HALF);
        pr0 = ps0[P_W+RND_SHIFT-1:RND_SHIFT];
        pr1 = ps1[P_W+RND_SHIFT-1:RND_SHIFT];
        ap0 = AP_W'(pr0 < 0 ? -pr0 : pr0);
        ap1 = AP_W'(pr1 < 0 ? -pr1 : pr1);
        dist_next.d_a_max = (da0_reg > da1_reg) ? da0_reg : da1_reg;
        dist_next.d_b0 = $signed(DIST_W'(ap0) - DIST_W'(ra0_reg) - DIST_W'(b_hl4_reg));
        dist_next.d_b1 = $signed(DIST_W'(ap1) - DIST_W'(ra1_reg) - DIST_W'(b_hw4_reg));
        st5_valid_next = st5_ready ? st4_valid_reg : st5_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
        end else begin
            st3_valid_reg <= st3_valid_next;
            st4_valid_reg <= st4_valid_next;
            st5_valid_reg <= st5_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (st3_ready) begin
            ta0_reg     <= ta0_next;
            ta1_reg     <= ta1_next;
            rb0_raw_reg <= rb0_raw_next;
            rb1_raw_reg <= rb1_raw_next;
            ra0_raw_reg <= ra0_raw_next;
            ra1_raw_reg <= ra1_raw_next;
            r00_reg     <= in_frame.r00;
            r01_reg     <= in_frame.r01;
            r10_reg     <= in_frame.r10;
            a_hl_reg    <= in_frame.a_half_len;
            a_hw_reg    <= in_frame.a_half_wid;
            b_hl3_reg   <= in_frame.b_half_len;
            b_hw3_reg   <= in_frame.b_half_wid;
        end
        if (st4_ready) begin
            da0_reg    <= da0_next;
            da1_reg    <= da1_next;
            p0_raw_reg <= p0_raw_next;
            p1_raw_reg <= p1_raw_next;
            ra0_reg    <= ra0_next;
            ra1_reg    <= ra1_next;
            b_hl4_reg  <= b_hl3_reg;
            b_hw4_reg  <= b_hw3_reg;
        end
        if (st5_ready) begin
            dist_reg <= dist_next;
        end
    end

endmodule

// ===== rtl/core/obbsat_gap.sv =====
// ----------------------------------------------------------------------------
// obbsat_gap: decision and output stage
// Picks the largest separation: overlap when it is not positive, else a
// saturated gap, held in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module obbsat_gap (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  obbsat_pkg::dist_t                in_dist,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             boxes_overlap,
    output logic [obbsat_pkg::GAP_W-1:0]     gap_estimate
);
    import obbsat_pkg::*;

    localparam logic signed [DIST_W-1:0] GapMax = DIST_W'((64'd1 << GAP_W) - 64'd1);

    logic                     valid_reg, valid_next;
    logic                     overlap_reg, overlap_next;
    logic [GAP_W-1:0]         gap_reg, gap_next;
    logic signed [DIST_W-1:0] best_b, best;

    assign in_ready      = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign boxes_overlap = overlap_reg;
    assign gap_estimate  = gap_reg;

    always_comb begin
        best_b = (in_dist.d_b0 > in_dist.d_b1) ? in_dist.d_b0 : in_dist.d_b1;
        best   = (in_dist.d_a_max > best_b) ? in_dist.d_a_max : best_b;
        if (best <= 0) begin
            overlap_next = 1'b1;
            gap_next     = '0;
        end else if (best > GapMax) begin
            overlap_next = 1'b0;
            gap_next     = GapMax[GAP_W-1:0];
        end else begin
            overlap_next = 1'b0;
            gap_next     = best[GAP_W-1:0];
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            overlap_reg <= overlap_next;
            gap_reg     <= gap_next;
        end
    end

endmodule
